>>> rtl/tga_pkg.sv
// ----------------------------------------------------------------------------
// tga_pkg
// Shared types and constants for the TGA image stream decoder: request
// layouts, result codes, header byte positions and image type codes.
// ----------------------------------------------------------------------------
package tga_pkg;

  // result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_TYPE = 2'd0;
  localparam logic [1:0] ERR_CMAP = 2'd1;
  localparam logic [1:0] ERR_BPP  = 2'd2;

  // header layout
  localparam logic [4:0] HDR_ID_LEN   = 5'd0;
  localparam logic [4:0] HDR_CMAP     = 5'd1;
  localparam logic [4:0] HDR_TYPE     = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_BPP      = 5'd16;
  localparam logic [4:0] HDR_LAST     = 5'd17;

  // image types
  localparam logic [7:0] IMG_TRUECOLOR = 8'd2;
  localparam logic [7:0] IMG_GRAY      = 8'd3;
  localparam logic [7:0] IMG_RLE       = 8'd10;

  // pixel sizes
  localparam logic [7:0] BPP_8  = 8'd8;
  localparam logic [7:0] BPP_24 = 8'd24;
  localparam logic [7:0] BPP_32 = 8'd32;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [7:0] RLE_RUN_BIT  = 8'h80;
  localparam logic [7:0] RLE_CNT_MASK = 8'h7f;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] pixel_index;
    logic [7:0]  run_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

endpackage

>>> rtl/tga_in_stage.sv
// ----------------------------------------------------------------------------
// tga_in_stage
// Input register: holds one byte request until the decode stage takes it.
// ----------------------------------------------------------------------------
module tga_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tga_pkg::in_item_t in_item,
  output logic              item_valid,
  output tga_pkg::in_item_t item,
  input  logic              take
);

  always_comb begin
    in_stall = item_valid && !take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

endmodule

>>> rtl/tga_decode.sv
// ----------------------------------------------------------------------------
// tga_decode
// Header parser, id skipper and pixel / RLE decoder with result register.
// ----------------------------------------------------------------------------
module tga_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  tga_pkg::in_item_t item,
  output logic              take,
  output logic              out_valid,
  input  logic              out_stall,
  output tga_pkg::result_t  result
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_IDSKIP,
    PH_PIXELS,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t      phase, phase_next, c_phase;
  logic [4:0]  hdr_count, hdr_count_next, c_hdr_count;
  logic [7:0]  id_skip, id_skip_next, c_id_skip;
  logic [7:0]  image_kind, image_kind_next, c_image_kind;
  logic [7:0]  bpp, bpp_next, c_bpp;
  logic        cmap_present, cmap_present_next, c_cmap_present;
  logic [15:0] width_reg, width_reg_next, c_width;
  logic [15:0] height_reg, height_reg_next, c_height;
  logic [7:0]  pkt_remaining, pkt_remaining_next, c_pkt_remaining;
  logic        pkt_is_run, pkt_is_run_next, c_pkt_is_run;
  logic [1:0]  comp_count, comp_count_next, c_comp_count;
  logic [23:0] color_hold, color_hold_next, c_color_hold;
  logic [31:0] next_pixel, next_pixel_next, c_next_pixel;
  logic [31:0] total_pixels, total_pixels_next, c_total_pixels;

  logic             has_result;
  tga_pkg::result_t res;
  logic [7:0]       b;
  logic             sof;
  logic [2:0]       nbytes;
  logic [7:0]       run_raw;
  logic [7:0]       run_clip;
  logic [31:0]      left;
  logic             is_rle;
  logic             type_ok;
  logic             bpp_ok;

  assign take = item_valid && (!out_valid || !out_stall);

  always_comb begin
    b   = item.data_byte;
    sof = item.start_of_file;

    c_phase         = sof ? PH_HEADER : phase;
    c_hdr_count     = sof ? 5'd0 : hdr_count;
    c_id_skip       = sof ? 8'd0 : id_skip;
    c_image_kind    = sof ? 8'd0 : image_kind;
    c_bpp           = sof ? 8'd0 : bpp;
    c_cmap_present  = sof ? 1'b0 : cmap_present;
    c_width         = sof ? 16'd0 : width_reg;
    c_height        = sof ? 16'd0 : height_reg;
    c_pkt_remaining = sof ? 8'd0 : pkt_remaining;
    c_pkt_is_run    = sof ? 1'b0 : pkt_is_run;
    c_comp_count    = sof ? 2'd0 : comp_count;
    c_color_hold    = sof ? 24'd0 : color_hold;
    c_next_pixel    = sof ? 32'd0 : next_pixel;
    c_total_pixels  = sof ? 32'd0 : total_pixels;

    phase_next         = c_phase;
    hdr_count_next     = c_hdr_count;
    id_skip_next       = c_id_skip;
    image_kind_next    = c_image_kind;
    bpp_next           = c_bpp;
    cmap_present_next  = c_cmap_present;
    width_reg_next     = c_width;
    height_reg_next    = c_height;
    pkt_remaining_next = c_pkt_remaining;
    pkt_is_run_next    = c_pkt_is_run;
    comp_count_next    = c_comp_count;
    color_hold_next    = c_color_hold;
    next_pixel_next    = c_next_pixel;
    total_pixels_next  = c_total_pixels;

    is_rle  = (c_image_kind == tga_pkg::IMG_RLE);
    type_ok = (c_image_kind == tga_pkg::IMG_TRUECOLOR) ||
              (c_image_kind == tga_pkg::IMG_GRAY) || is_rle;
    bpp_ok  = (c_bpp == tga_pkg::BPP_24) || (c_bpp == tga_pkg::BPP_32) ||
              ((c_image_kind == tga_pkg::IMG_GRAY) && (c_bpp == tga_pkg::BPP_8));
    nbytes  = c_bpp[5:3];
    left    = c_total_pixels - c_next_pixel;
    run_raw = (is_rle && c_pkt_is_run) ? c_pkt_remaining : 8'd1;
    run_clip = ({24'd0, run_raw} > left) ? left[7:0] : run_raw;

    has_result       = 1'b0;
    res              = '0;
    res.image_width  = c_width;
    res.image_height = c_height;

    case (c_phase)
      PH_HEADER: begin
        case (c_hdr_count)
          tga_pkg::HDR_ID_LEN:    id_skip_next = b;
          tga_pkg::HDR_CMAP:      cmap_present_next = (b != 8'd0);
          tga_pkg::HDR_TYPE:      image_kind_next = b;
          tga_pkg::HDR_WIDTH_LO:  width_reg_next = {c_width[15:8], b};
          tga_pkg::HDR_WIDTH_HI:  width_reg_next = {b, c_width[7:0]};
          tga_pkg::HDR_HEIGHT_LO: height_reg_next = {c_height[15:8], b};
          tga_pkg::HDR_HEIGHT_HI: height_reg_next = {b, c_height[7:0]};
          tga_pkg::HDR_BPP:       bpp_next = b;
          default: begin
          end
        endcase
        hdr_count_next = c_hdr_count + 5'd1;
        if (c_hdr_count == tga_pkg::HDR_LAST) begin
          has_result = 1'b1;
          if (!type_ok || c_cmap_present || !bpp_ok) begin
            phase_next      = PH_ERROR;
            res.result_kind = tga_pkg::KIND_ERROR;
            res.last        = 1'b1;
            if (!type_ok) begin
              res.error_code = tga_pkg::ERR_TYPE;
            end else if (c_cmap_present) begin
              res.error_code = tga_pkg::ERR_CMAP;
            end else begin
              res.error_code = tga_pkg::ERR_BPP;
            end
          end else begin
            total_pixels_next = {16'd0, c_width} * {16'd0, c_height};
            next_pixel_next   = 32'd0;
            res.result_kind   = tga_pkg::KIND_HEADER;
            if (c_width == 16'd0 || c_height == 16'd0) begin
              phase_next = PH_DONE;
              res.last   = 1'b1;
            end else if (c_id_skip != 8'd0) begin
              phase_next = PH_IDSKIP;
            end else begin
              phase_next = PH_PIXELS;
            end
          end
        end
      end
      PH_IDSKIP: begin
        id_skip_next = c_id_skip - 8'd1;
        if (c_id_skip == 8'd1) begin
          phase_next = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (is_rle && c_pkt_remaining == 8'd0) begin
          pkt_remaining_next = (b & tga_pkg::RLE_CNT_MASK) + 8'd1;
          pkt_is_run_next    = ((b & tga_pkg::RLE_RUN_BIT) != 8'd0);
          comp_count_next    = 2'd0;
        end else if ({1'b0, c_comp_count} + 3'd1 < nbytes) begin
          case (c_comp_count)
            2'd0:    color_hold_next = c_color_hold | {16'd0, b};
            2'd1:    color_hold_next = c_color_hold | {8'd0, b, 8'd0};
            default: color_hold_next = c_color_hold | {b, 16'd0};
          endcase
          comp_count_next = c_comp_count + 2'd1;
        end else begin
          has_result = 1'b1;
          if (nbytes == 3'd1) begin
            res.red   = b;
            res.green = b;
            res.blue  = b;
            res.alpha = tga_pkg::ALPHA_OPAQUE;
          end else if (nbytes == 3'd3) begin
            res.red   = b;
            res.green = c_color_hold[15:8];
            res.blue  = c_color_hold[7:0];
            res.alpha = tga_pkg::ALPHA_OPAQUE;
          end else begin
            res.red   = c_color_hold[23:16];
            res.green = c_color_hold[15:8];
            res.blue  = c_color_hold[7:0];
            res.alpha = b;
          end
          comp_count_next = 2'd0;
          color_hold_next = 24'd0;
          if (is_rle) begin
            if (c_pkt_is_run) begin
              pkt_remaining_next = 8'd0;
            end else begin
              pkt_remaining_next = c_pkt_remaining - 8'd1;
            end
          end
          res.result_kind = tga_pkg::KIND_PIXEL;
          res.pixel_index = c_next_pixel;
          res.run_length  = run_clip;
          next_pixel_next = c_next_pixel + {24'd0, run_clip};
          if ({24'd0, run_raw} >= left) begin
            phase_next = PH_DONE;
            res.last   = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      hdr_count     <= 5'd0;
      id_skip       <= 8'd0;
      image_kind    <= 8'd0;
      bpp           <= 8'd0;
      cmap_present  <= 1'b0;
      width_reg     <= 16'd0;
      height_reg    <= 16'd0;
      pkt_remaining <= 8'd0;
      pkt_is_run    <= 1'b0;
      comp_count    <= 2'd0;
      color_hold    <= 24'd0;
      next_pixel    <= 32'd0;
      total_pixels  <= 32'd0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        hdr_count     <= hdr_count_next;
        id_skip       <= id_skip_next;
        image_kind    <= image_kind_next;
        bpp           <= bpp_next;
        cmap_present  <= cmap_present_next;
        width_reg     <= width_reg_next;
        height_reg    <= height_reg_next;
        pkt_remaining <= pkt_remaining_next;
        pkt_is_run    <= pkt_is_run_next;
        comp_count    <= comp_count_next;
        color_hold    <= color_hold_next;
        next_pixel    <= next_pixel_next;
        total_pixels  <= total_pixels_next;
      end
      if (take && has_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_result) begin
      result <= res;
    end
  end

  a_pixel_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.result_kind == tga_pkg::KIND_PIXEL |-> result.run_length != 8'd0)
    else $error("pixel result with zero run length");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.result_kind == tga_pkg::KIND_ERROR |-> result.last)
    else $error("error result without last");

  a_pixels_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PIXELS |-> next_pixel < total_pixels)
    else $error("pixel counter reached image end while decoding");

  a_header_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> hdr_count <= tga_pkg::HDR_LAST)
    else $error("header byte count past header end");

endmodule

>>> rtl/tga_image_stream_decoder.sv
// ----------------------------------------------------------------------------
// tga_image_stream_decoder
// Byte-serial TGA decoder giving header, error and RGBA pixel/run results.
// ----------------------------------------------------------------------------
// One file byte is taken per cycle unless in_stall is high, with start_of_file
// marking byte zero of a new image. The 18-byte header yields one header or
// error result, the id field is skipped, then types 2 and 3 give one result
// per pixel and type 10 gives one result per raw pixel or per run packet,
// clipped at the image end. Every byte takes one pass through the decode
// stage, so requests are taken back to back at one byte per cycle while the
// result side does not stall; a result passes through the input register,
// then the result register. A stall on the result side backs up through the
// one input register.
module tga_image_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [31:0] pixel_index,
  output logic [7:0]  run_length,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic [1:0]  error_code,
  output logic        last
);

  tga_pkg::in_item_t in_item;
  tga_pkg::in_item_t item;
  tga_pkg::result_t  result;
  logic              item_valid;
  logic              take;

  assign in_item.data_byte     = data_byte;
  assign in_item.start_of_file = start_of_file;

  tga_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  tga_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign result_kind  = result.result_kind;
  assign pixel_index  = result.pixel_index;
  assign run_length   = result.run_length;
  assign red          = result.red;
  assign green        = result.green;
  assign blue         = result.blue;
  assign alpha        = result.alpha;
  assign image_width  = result.image_width;
  assign image_height = result.image_height;
  assign error_code   = result.error_code;
  assign last         = result.last;

endmodule
